// File: rtl/vhd_pkg.sv
// Package for the hard-decision Viterbi decoder: trellis sizes, sequencer states,
// and the expected code bit function. No dependencies.
`default_nettype none
package vhd_pkg;
  localparam int K      = 7;
  localparam int SW     = K - 1;
  localparam int NST    = 1 << SW;
  localparam int TL     = 32;
  localparam int CW     = $clog2(TL);
  localparam int MW     = 9;
  localparam int NOUT   = 4;
  localparam logic [MW-1:0] MET_INF = 9'd511;
  localparam logic [MW-1:0] MET_MAX = 9'd510;

  localparam logic [2:0] REG_N  = 3'd0;
  localparam logic [2:0] REG_G0 = 3'd1;
  localparam logic [2:0] REG_G1 = 3'd2;
  localparam logic [2:0] REG_G2 = 3'd3;
  localparam logic [2:0] REG_G3 = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACS  = 5'b00010,
    S_TBA  = 5'b00100,
    S_TBD  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  typedef logic [NOUT-1:0][K-1:0] gens_t;

  function automatic logic [NOUT-1:0] exp_bits(input logic [2:0] n, input gens_t g,
                                               input logic [K-1:0] r);
    logic [NOUT-1:0] e;
    e = '0;
    for (int j = 0; j < NOUT; j++) begin
      if (3'(j) < n) e[2'(n - 3'(j) - 3'd1)] = ^(g[j] & r);
    end
    return e;
  endfunction

  function automatic logic [2:0] ones4(input logic [NOUT-1:0] v);
    return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
  endfunction

  function automatic logic [MW-1:0] branch(input logic [MW-1:0] m, input logic [2:0] d);
    logic [MW:0] s;
    s = {1'b0, m} + (MW+1)'(d);
    if (m == MET_INF) return MET_INF;
    return (s > {1'b0, MET_MAX}) ? MET_MAX : s[MW-1:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/vhd_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none
module vhd_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/viterbi_hard_decision_decoder_unit.sv
// Hard-decision Viterbi decoder with block traceback, one shared ACS unit.
// Depends on vhd_pkg and vhd_ram.
// Each word is accepted in S_IDLE, then runs ACS, one state per cycle, with the
// p_v/p_i register stage covering the metric RAM read. The word closing a window
// (the 32nd, then every 31st) first runs a traceback (S_TBA then S_TBD per column
// via the survivor RAM read) and emits 31 bits, at most one per cycle, before ACS.
// Synchronous active-high reset restores default config and state-0 start metrics.
`default_nettype none
module viterbi_hard_decision_decoder_unit import vhd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] received_codeword,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            decoded_bit,
  output logic [7:0]      block_metric,
  output logic            last_bit,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data
);
  state_t          state;
  logic [2:0]      code_outputs;
  gens_t           gens;
  logic [2:0]      n_eff;
  logic [3:0]      cw;
  logic [CW-1:0]   step;
  logic [SW:0]     acs_cnt;
  logic            p_v;
  logic [SW-1:0]   p_i;
  logic            cur;
  logic            fresh;
  logic [SW-1:0]   origin;
  logic [SW-1:0]   best_state;
  logic [MW-1:0]   minm;
  logic [SW-1:0]   x;
  logic [CW-1:0]   col;
  logic [TL-2:0]   seq;
  logic [CW-1:0]   k;
  logic            sv_rd;
  logic [MW-1:0]   mrd [2][2];
  logic [MW-1:0]   m0_raw, m1_raw, m0, m1, mnew;
  logic            sel;
  logic [SW-1:0]   c0, c1;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign n_eff     = (code_outputs > 3'd4) ? 3'd4 : code_outputs;

  assign c0 = {p_i[SW-2:0], 1'b0};
  assign c1 = {p_i[SW-2:0], 1'b1};
  assign m0_raw = fresh ? ((c0 == origin) ? '0 : MET_INF) : mrd[cur][0];
  assign m1_raw = fresh ? ((c1 == origin) ? '0 : MET_INF) : mrd[cur][1];
  assign m0 = branch(m0_raw, ones4(exp_bits(n_eff, gens, {p_i, 1'b0}) ^ cw));
  assign m1 = branch(m1_raw, ones4(exp_bits(n_eff, gens, {p_i, 1'b1}) ^ cw));
  assign sel  = (m0 > m1);
  assign mnew = sel ? m1 : m0;

  for (genvar b = 0; b < 2; b++) begin : g_buf
    for (genvar e = 0; e < 2; e++) begin : g_bank
      vhd_ram #(.W(MW), .D(NST/2)) u_met (
        .clk   (clk),
        .we    (p_v && (cur != 1'(b)) && (p_i[0] == 1'(e))),
        .waddr (p_i[SW-1:1]),
        .wdata (mnew),
        .raddr (acs_cnt[SW-2:0]),
        .rdata (mrd[b][e])
      );
    end
  end

  vhd_ram #(.W(1), .D(NST*TL)) u_surv (
    .clk   (clk),
    .we    (p_v),
    .waddr ({p_i, step}),
    .wdata (sel),
    .raddr ({x, col}),
    .rdata (sv_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      code_outputs <= 3'd2;
      gens         <= {7'd0, 7'd0, 7'd109, 7'd79};
      step         <= '0;
      acs_cnt      <= '0;
      p_v          <= 1'b0;
      cur          <= 1'b0;
      fresh        <= 1'b1;
      origin       <= '0;
      best_state   <= '0;
      minm         <= MET_INF;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_N:   code_outputs <= cfg_data[2:0];
          REG_G0:  gens[0] <= cfg_data;
          REG_G1:  gens[1] <= cfg_data;
          REG_G2:  gens[2] <= cfg_data;
          REG_G3:  gens[3] <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cw      <= received_codeword & 4'((5'd1 << n_eff) - 5'd1);
            acs_cnt <= '0;
            if (step == CW'(TL-1)) begin
              step  <= CW'(1);
              x     <= best_state;
              col   <= CW'(TL-1);
              state <= S_TBA;
            end else begin
              step  <= step + CW'(1);
              minm  <= MET_INF;
              state <= S_ACS;
            end
          end
        end
        S_ACS: begin
          p_v <= !acs_cnt[SW];
          p_i <= acs_cnt[SW-1:0];
          if (!acs_cnt[SW]) acs_cnt <= acs_cnt + (SW+1)'(1);
          if (p_v) begin
            if (mnew < minm) begin
              minm       <= mnew;
              best_state <= p_i;
            end
            if (p_i == SW'(NST-1)) begin
              cur   <= !cur;
              fresh <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        S_TBA: state <= S_TBD;
        S_TBD: begin
          x   <= {x[SW-2:0], sv_rd};
          seq <= {seq[TL-3:0], x[SW-2]};
          col <= col - CW'(1);
          if (col == CW'(1)) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_TBA;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            decoded_bit  <= seq[0];
            block_metric <= (minm > 9'd255) ? 8'd255 : minm[7:0];
            last_bit     <= (k == CW'(TL-2));
            seq          <= seq >> 1;
            k            <= k + CW'(1);
            if (k == CW'(TL-2)) begin
              fresh  <= 1'b1;
              origin <= best_state;
              minm   <= MET_INF;
              state  <= S_ACS;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
